@@ design/bse_pkg.sv @@
// Shared types, constants and arithmetic helpers of the Bernstein surface evaluator.
package bse_pkg;

    // Grid size default and the largest grid the datapath widths are sized for.
    localparam int GRID_POINTS_DEF = 4;
    localparam int GRID_POINTS_MAX = 8;

    // Field widths.
    localparam int SMP_W = 16;
    localparam int CO_W  = 16;
    localparam int OUT_W = 32;
    localparam int ST_W  = 2;
    localparam int CFG_W = 16;

    // Datapath widths, sized for the largest grid.
    localparam int FRAC  = 16;
    localparam int D_W   = 16;
    localparam int Q_W   = FRAC + 1;
    localparam int U_W   = FRAC + 2;
    localparam int F_W   = FRAC + 3;
    localparam int P_W   = 26;
    localparam int BIN_W = 6;
    localparam int B_W   = 32;
    localparam int W_W   = 42;
    localparam int ACC_W = 64;
    localparam int DC_W  = $clog2(Q_W);

    localparam logic signed [F_W-1:0] ONE_Q16 = F_W'(1 << FRAC);

    // Operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_NARROW = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_FIRST_LOW   = 2'd0;
    localparam logic [1:0] REG_FIRST_HIGH  = 2'd1;
    localparam logic [1:0] REG_SECOND_LOW  = 2'd2;
    localparam logic [1:0] REG_SECOND_HIGH = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic grid_wr;
        logic check;
        logic axis;
        logic div_step;
        logic div_last;
        logic p_mul;
        logic p_first;
        logic p_use_u;
        logic b_store;
        logic cell_rd;
        logic mac;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [ST_W-1:0] check_code;
    } t_sts;

    // Arithmetic right shift rounding to nearest, ties away from zero.
    function automatic logic signed [63:0] round_shr(input logic signed [63:0] v, input int s);
        logic [63:0] mag;
        logic [63:0] res;
        mag = v[63] ? 64'(-v) : 64'(v);
        res = (mag + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(res) : $signed(res);
    endfunction

    // Saturate a wide signed value to the 32-bit output range.
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[OUT_W-1:0];
    endfunction

    // Binomial coefficient through Pascal's triangle, evaluated at elaboration.
    function automatic int binom(input int n, input int k);
        int row [0:GRID_POINTS_MAX];
        for (int c = 0; c <= GRID_POINTS_MAX; c++) begin
            row[c] = (c == 0) ? 1 : 0;
        end
        for (int r = 1; r <= n; r++) begin
            for (int c = GRID_POINTS_MAX; c >= 1; c--) begin
                row[c] = row[c] + row[c-1];
            end
        end
        return row[k];
    endfunction

endpackage

@@ design/bse_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface bse_in_if;
    import bse_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic [1:0]               grid_row;
    logic [1:0]               grid_col;
    logic signed [CO_W-1:0]   mean_coeff;
    logic signed [CO_W-1:0]   dev_coeff;
    logic signed [SMP_W-1:0]  sample_a;
    logic signed [SMP_W-1:0]  sample_b;

    modport source (output valid, opcode, grid_row, grid_col, mean_coeff, dev_coeff,
                    sample_a, sample_b, input ready);
    modport sink (input valid, opcode, grid_row, grid_col, mean_coeff, dev_coeff,
                  sample_a, sample_b, output ready);
endinterface

interface bse_out_if;
    import bse_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  mean_out;
    logic signed [OUT_W-1:0]  dev_out;
    logic [ST_W-1:0]          status;

    modport source (output valid, mean_out, dev_out, status, input ready);
    modport sink (input valid, mean_out, dev_out, status, output ready);
endinterface

@@ design/bse_ctrl.sv @@
// Controller state machine that sequences normalization, basis and grid accumulation.
module bse_ctrl
    import bse_pkg::*;
#(
    parameter int GRID_POINTS = GRID_POINTS_DEF,
    localparam int IDX_W = $clog2(GRID_POINTS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_opcode,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  t_sts             i_sts,
    output t_cmd             o_cmd,
    output logic [IDX_W-1:0] o_idx_a,
    output logic [IDX_W-1:0] o_idx_b
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_DIV      = 4'd2;
    localparam logic [3:0] S_BASIS    = 4'd3;
    localparam logic [3:0] S_CELL_RD  = 4'd4;
    localparam logic [3:0] S_CELL_MAC = 4'd5;
    localparam logic [3:0] S_FINISH   = 4'd6;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(GRID_POINTS - 1);
    localparam logic [DC_W-1:0]  DIV_LAST = DC_W'(Q_W - 1);

    logic [3:0]       r_state, n_state;
    logic             r_axis, n_axis;
    logic [DC_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0] r_a, n_a;
    logic [IDX_W-1:0] r_b, n_b;
    logic             r_out_valid, n_out_valid;

    // Next-state and command decode.
    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_cnt       = r_cnt;
        n_a         = r_a;
        n_b         = r_b;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.axis  = r_axis;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_in_opcode == OP_LOAD) begin
                        o_cmd.grid_wr = 1'b1;
                        n_state       = S_FINISH;
                    end else begin
                        n_axis  = 1'b0;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_cnt       = '0;
                n_state     = (i_sts.check_code != ST_OK) ? S_FINISH : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == DIV_LAST) begin
                    o_cmd.div_last = 1'b1;
                    n_a            = '0;
                    n_b            = '0;
                    if (!r_axis) begin
                        n_axis  = 1'b1;
                        n_state = S_CHECK;
                    end else begin
                        n_axis  = 1'b0;
                        n_state = S_BASIS;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_BASIS: begin
                // r_a is the basis index, r_b the factor count within it.
                if (r_b != IDX_LAST) begin
                    o_cmd.p_mul   = 1'b1;
                    o_cmd.p_first = (r_b == '0);
                    o_cmd.p_use_u = (r_b < r_a);
                    n_b           = r_b + 1'b1;
                end else begin
                    o_cmd.b_store = 1'b1;
                    n_b           = '0;
                    if (r_a == IDX_LAST) begin
                        n_a = '0;
                        if (!r_axis) begin
                            n_axis = 1'b1;
                        end else begin
                            n_state = S_CELL_RD;
                        end
                    end else begin
                        n_a = r_a + 1'b1;
                    end
                end
            end
            S_CELL_RD: begin
                o_cmd.cell_rd = 1'b1;
                n_state       = S_CELL_MAC;
            end
            S_CELL_MAC: begin
                o_cmd.mac = 1'b1;
                n_state   = S_CELL_RD;
                if (r_b == IDX_LAST) begin
                    n_b = '0;
                    if (r_a == IDX_LAST) begin
                        n_state = S_FINISH;
                    end else begin
                        n_a = r_a + 1'b1;
                    end
                end else begin
                    n_b = r_b + 1'b1;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_cnt       <= '0;
            r_a         <= '0;
            r_b         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_cnt       <= n_cnt;
            r_a         <= n_a;
            r_b         <= n_b;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_idx_a     = r_a;
    assign o_idx_b     = r_b;

endmodule

@@ design/bse_dp.sv @@
// Datapath: divider, shared basis multiplier, grid memories and accumulators.
module bse_dp
    import bse_pkg::*;
#(
    parameter int GRID_POINTS = GRID_POINTS_DEF,
    localparam int IDX_W = $clog2(GRID_POINTS),
    localparam int CELLS = GRID_POINTS * GRID_POINTS,
    localparam int CA_W  = $clog2(CELLS)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic [IDX_W-1:0]         i_idx_a,
    input  logic [IDX_W-1:0]         i_idx_b,
    input  logic [1:0]               i_grid_row,
    input  logic [1:0]               i_grid_col,
    input  logic signed [CO_W-1:0]   i_mean_coeff,
    input  logic signed [CO_W-1:0]   i_dev_coeff,
    input  logic signed [SMP_W-1:0]  i_sample_a,
    input  logic signed [SMP_W-1:0]  i_sample_b,
    input  logic signed [CFG_W-1:0]  i_first_low,
    input  logic signed [CFG_W-1:0]  i_first_high,
    input  logic signed [CFG_W-1:0]  i_second_low,
    input  logic signed [CFG_W-1:0]  i_second_high,
    output t_sts                     o_sts,
    output logic signed [OUT_W-1:0]  o_mean_out,
    output logic signed [OUT_W-1:0]  o_dev_out,
    output logic [ST_W-1:0]          o_status
);

    // Sample and status registers.
    logic signed [SMP_W-1:0] r_smp_a, r_smp_b;
    logic [ST_W-1:0]         r_status;

    // Divider registers.
    logic [D_W-1:0]          r_d;
    logic                    r_neg;
    logic [Q_W+1:0]          r_rem;
    logic [Q_W-1:0]          r_nsh;
    logic [Q_W-1:0]          r_q;
    logic signed [U_W-1:0]   r_u, r_v;

    // Basis registers.
    logic signed [P_W-1:0]   r_p;
    logic signed [B_W-1:0]   r_bu [GRID_POINTS];
    logic signed [B_W-1:0]   r_bv [GRID_POINTS];

    // Grid memories and the accumulation stage.
    logic signed [CO_W-1:0]  r_mean_mem [CELLS];
    logic signed [CO_W-1:0]  r_dev_mem  [CELLS];
    logic [CELLS-1:0]        r_vld;
    logic signed [CO_W-1:0]  r_mrd, r_drd;
    logic signed [W_W-1:0]   r_w;
    logic signed [ACC_W-1:0] r_macc, r_dacc;
    logic signed [OUT_W-1:0] r_mean_out, r_dev_out;
    logic [ST_W-1:0]         r_st_out;

    logic [BIN_W-1:0]        w_binom [GRID_POINTS];

    // Binomial coefficients of degree GRID_POINTS-1.
    for (genvar g = 0; g < GRID_POINTS; g++) begin : g_binom
        assign w_binom[g] = BIN_W'(binom(GRID_POINTS - 1, g));
    end

    // Bounds and range check of the selected sample.
    logic signed [SMP_W-1:0] w_x, w_lo, w_hi;
    logic signed [D_W:0]     w_d, w_num;
    logic [D_W:0]            w_mag;
    logic [2*Q_W:0]          w_numer;

    always_comb begin
        w_x   = i_cmd.axis ? r_smp_b : r_smp_a;
        w_lo  = i_cmd.axis ? i_second_low : i_first_low;
        w_hi  = i_cmd.axis ? i_second_high : i_first_high;
        w_d   = (D_W+1)'(w_hi) - (D_W+1)'(w_lo);
        w_num = (D_W+1)'(w_x) - (D_W+1)'(w_lo);
        w_mag = w_num[D_W] ? (D_W+1)'(-w_num) : (D_W+1)'(w_num);
        if (w_d[D_W] || (w_d == '0)) begin
            o_sts.check_code = ST_NARROW;
        end else if (w_mag > $unsigned(w_d)) begin
            o_sts.check_code = ST_RANGE;
        end else begin
            o_sts.check_code = ST_OK;
        end
        w_numer = {1'b0, w_mag, {Q_W{1'b0}}} + (2*Q_W+1)'($unsigned(w_d));
    end

    // One quotient bit per step of the restoring divider.
    logic [Q_W+1:0]        w_t, w_den;
    logic                  w_ge;
    logic [Q_W-1:0]        w_q_nx;
    logic signed [U_W-1:0] w_qs;

    always_comb begin
        w_t    = {r_rem[Q_W:0], r_nsh[Q_W-1]};
        w_den  = {2'b00, r_d, 1'b0};
        w_ge   = (w_t >= w_den);
        w_q_nx = {r_q[Q_W-2:0], w_ge};
        w_qs   = r_neg ? -$signed({1'b0, w_q_nx}) : $signed({1'b0, w_q_nx});
    end

    // Shared basis multiplier: a product of factors, then the binomial.
    logic signed [U_W-1:0]     w_tv;
    logic signed [F_W-1:0]     w_fac, w_pop;
    logic signed [P_W+F_W-1:0] w_pm;
    logic signed [P_W+BIN_W:0] w_bm;
    logic signed [63:0]        w_prnd;

    always_comb begin
        w_tv   = i_cmd.axis ? r_v : r_u;
        w_fac  = i_cmd.p_use_u ? F_W'(w_tv) : (ONE_Q16 - F_W'(w_tv));
        w_pop  = i_cmd.p_first ? ONE_Q16 : F_W'(r_p);
        w_pm   = i_cmd.p_first ? (P_W+F_W)'(w_pop) * (P_W+F_W)'(w_fac)
                               : (P_W+F_W)'(r_p) * (P_W+F_W)'(w_fac);
        w_prnd = round_shr(64'(w_pm), FRAC);
        w_bm   = (P_W+BIN_W+1)'(r_p) * $signed({1'b0, w_binom[i_idx_a]});
    end

    // Grid addresses and products of the accumulation stage.
    logic [CA_W-1:0]          w_waddr, w_raddr;
    logic                     w_wr_ok;
    logic signed [2*B_W-1:0]  w_bb;
    logic signed [W_W+CO_W-1:0] w_tm, w_td;

    always_comb begin
        w_wr_ok = (int'(i_grid_row) < GRID_POINTS) && (int'(i_grid_col) < GRID_POINTS);
        w_waddr = CA_W'(int'(i_grid_row) * GRID_POINTS + int'(i_grid_col));
        w_raddr = CA_W'(int'(i_idx_a) * GRID_POINTS + int'(i_idx_b));
        w_bb    = (2*B_W)'(r_bu[i_idx_a]) * (2*B_W)'(r_bv[i_idx_b]);
        w_tm    = (W_W+CO_W)'(r_w) * (W_W+CO_W)'(r_mrd);
        w_td    = (W_W+CO_W)'(r_w) * (W_W+CO_W)'(r_drd);
    end

    // Valid bits of the grid entries; an unwritten entry reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.grid_wr && w_wr_ok) begin
            r_vld[w_waddr] <= 1'b1;
        end
    end

    // Grid memories, written on a load and read with a registered port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.grid_wr && w_wr_ok) begin
            r_mean_mem[w_waddr] <= i_mean_coeff;
            r_dev_mem[w_waddr]  <= i_dev_coeff;
        end
        if (i_cmd.cell_rd) begin
            r_mrd <= r_vld[w_raddr] ? r_mean_mem[w_raddr] : '0;
            r_drd <= r_vld[w_raddr] ? r_dev_mem[w_raddr] : '0;
        end
    end

    // Status register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= ST_OK;
        end else if (i_cmd.capture) begin
            r_status <= ST_OK;
        end else if (i_cmd.check && (o_sts.check_code != ST_OK)) begin
            r_status <= o_sts.check_code;
        end
    end

    // Payload registers of the arithmetic.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_smp_a <= i_sample_a;
            r_smp_b <= i_sample_b;
            r_macc  <= '0;
            r_dacc  <= '0;
        end
        if (i_cmd.check) begin
            r_d   <= w_d[D_W-1:0];
            r_neg <= w_num[D_W];
            r_rem <= {1'b0, w_numer[2*Q_W:Q_W]};
            r_nsh <= w_numer[Q_W-1:0];
            r_q   <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? (w_t - w_den) : w_t;
            r_nsh <= {r_nsh[Q_W-2:0], 1'b0};
            r_q   <= w_q_nx;
        end
        if (i_cmd.div_last) begin
            if (i_cmd.axis) begin
                r_v <= w_qs;
            end else begin
                r_u <= w_qs;
            end
        end
        if (i_cmd.p_mul) begin
            r_p <= w_prnd[P_W-1:0];
        end
        if (i_cmd.b_store) begin
            if (i_cmd.axis) begin
                r_bv[i_idx_a] <= w_bm[B_W-1:0];
            end else begin
                r_bu[i_idx_a] <= w_bm[B_W-1:0];
            end
        end
        if (i_cmd.cell_rd) begin
            r_w <= W_W'(round_shr(64'(w_bb), FRAC));
        end
        if (i_cmd.mac) begin
            r_macc <= r_macc + ACC_W'(w_tm);
            r_dacc <= r_dacc + ACC_W'(w_td);
        end
        if (i_cmd.out_load) begin
            r_mean_out <= sat_out(round_shr(64'(r_macc), 4));
            r_dev_out  <= sat_out(round_shr(64'(r_dacc), 4));
            r_st_out   <= r_status;
        end
    end

    assign o_mean_out = r_mean_out;
    assign o_dev_out  = r_dev_out;
    assign o_status   = r_st_out;

endmodule

@@ design/bernstein_surface_eval_core.sv @@
// Top level of the Bernstein surface evaluator: register port, controller and datapath.
// A load writes its grid entry and then loads its result in the finish state; an evaluate
// checks and divides each axis in turn in the bit-serial divider, forms the basis of both
// axes in the shared basis multiplier and accumulates every grid cell. A bounds or range
// failure on either axis goes straight to the finish state. One item is in flight at a
// time; the next transfer is taken the cycle after the result is loaded, later while the
// output stalls. Synchronous active-low reset restores bounds and makes the grid read as zero.
module bernstein_surface_eval_core
    import bse_pkg::*;
#(
    parameter int GRID_POINTS = GRID_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bse_in_if.sink      i_in,
    bse_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(GRID_POINTS);

    logic signed [CFG_W-1:0] r_first_low, r_first_high, r_second_low, r_second_high;
    logic signed [CFG_W-1:0] w_rd;
    t_cmd                    w_cmd;
    t_sts                    w_sts;
    logic [IDX_W-1:0]        w_idx_a, w_idx_b;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_low   <= 16'sd0;
            r_first_high  <= 16'sd256;
            r_second_low  <= 16'sd0;
            r_second_high <= 16'sd256;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_FIRST_LOW:   r_first_low   <= pwdata[CFG_W-1:0];
                REG_FIRST_HIGH:  r_first_high  <= pwdata[CFG_W-1:0];
                REG_SECOND_LOW:  r_second_low  <= pwdata[CFG_W-1:0];
                REG_SECOND_HIGH: r_second_high <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read decode.
    always_comb begin
        unique case (paddr[3:2])
            REG_FIRST_LOW:   w_rd = r_first_low;
            REG_FIRST_HIGH:  w_rd = r_first_high;
            REG_SECOND_LOW:  w_rd = r_second_low;
            REG_SECOND_HIGH: w_rd = r_second_high;
            default:         w_rd = '0;
        endcase
    end

    assign prdata = 32'(w_rd);
    assign pready = 1'b1;

    // Sequencer.
    bse_ctrl #(
        .GRID_POINTS (GRID_POINTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (i_in.opcode),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_idx_a     (w_idx_a),
        .o_idx_b     (w_idx_b)
    );

    // Arithmetic and grid storage.
    bse_dp #(
        .GRID_POINTS (GRID_POINTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_idx_a       (w_idx_a),
        .i_idx_b       (w_idx_b),
        .i_grid_row    (i_in.grid_row),
        .i_grid_col    (i_in.grid_col),
        .i_mean_coeff  (i_in.mean_coeff),
        .i_dev_coeff   (i_in.dev_coeff),
        .i_sample_a    (i_in.sample_a),
        .i_sample_b    (i_in.sample_b),
        .i_first_low   (r_first_low),
        .i_first_high  (r_first_high),
        .i_second_low  (r_second_low),
        .i_second_high (r_second_high),
        .o_sts         (w_sts),
        .o_mean_out    (o_out.mean_out),
        .o_dev_out     (o_out.dev_out),
        .o_status      (o_out.status)
    );

`ifndef SYNTHESIS
    // A transfer in starts work, so the block takes no item in the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input taken while an item is in progress");

    // A failing status comes with zero results.
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status != ST_OK) |->
            (o_out.mean_out == '0) && (o_out.dev_out == '0))
        else $error("nonzero result with failing status");

    // Only defined status codes reach the output.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.status == ST_OK) || (o_out.status == ST_NARROW) ||
            (o_out.status == ST_RANGE))
        else $error("undefined status code");
`endif

endmodule
